### rtl/address_substitute_group_lookup_defines.svh
// ----------------------------------------------------------------------------
// Address substitute group lookup: assertion macros
// Concurrent checks on clk; compiled out when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_SUBSTITUTE_GROUP_LOOKUP_DEFINES_SVH
`define ADDRESS_SUBSTITUTE_GROUP_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
`define ASGL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASGL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASGL_ASSERT(label, prop, msg)
`define ASGL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### rtl/asgl_pkg.sv
// ----------------------------------------------------------------------------
// Address substitute group lookup: package
// Sizes, word types, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package asgl_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int ADDRESS_BITS = 48;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [47:0]             field_addr_t;
    typedef logic [5:0]              field_idx_t;
    typedef logic [1:0]              cmd_code_t;

    localparam cmd_code_t CMD_CLEAR  = 2'd0;
    localparam cmd_code_t CMD_APPEND = 2'd1;
    localparam cmd_code_t CMD_QUERY  = 2'd2;

    typedef struct packed {
        cmd_code_t   cmd;
        field_addr_t address;
        logic        ends_group;
    } item_t;

    typedef struct packed {
        field_addr_t result_address;
        field_idx_t  group_number;
        field_idx_t  entry_in_group;
        logic        has_subst;
        logic        last;
        logic        status;
    } result_t;

    typedef struct packed {
        logic  mark;
        addr_t addr;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_MEMBER,
        ST_EMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic rd_restart;
        logic consume;
        logic set_member;
        logic next_group;
        logic take_cand;
        logic load_single;
        logic load_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic more;
        logic rd_valid;
        logic match;
        logic data_end;
        logic data_last;
        logic member;
        logic pend_valid;
        logic out_free;
    } ctrl_status_t;

endpackage

### rtl/asgl_ctrl.sv
// ----------------------------------------------------------------------------
// Address substitute group lookup: controller
// Sequences clear, append and the two-pass group scan of a query.
// ----------------------------------------------------------------------------
module asgl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  asgl_pkg::cmd_code_t    item_cmd,
    input  asgl_pkg::ctrl_status_t status,
    output logic                   item_stall,
    output asgl_pkg::ctrl_cmd_t    cmd
);

    asgl_pkg::state_t state_reg;
    asgl_pkg::state_t state_next;
    logic             block;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asgl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        block      = status.rd_valid && !status.match && status.pend_valid && !status.out_free;
        case (state_reg)
            asgl_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    case (item_cmd)
                        asgl_pkg::CMD_QUERY:
                        begin
                            state_next = status.count_zero ? asgl_pkg::ST_FINISH
                                                           : asgl_pkg::ST_MEMBER;
                        end
                        default:
                        begin
                            state_next = asgl_pkg::ST_SINGLE;
                        end
                    endcase
                end
            end
            asgl_pkg::ST_SINGLE:
            begin
                if (status.out_free)
                begin
                    cmd.load_single = 1'b1;
                    state_next      = asgl_pkg::ST_IDLE;
                end
            end
            asgl_pkg::ST_MEMBER:
            begin
                cmd.consume = status.rd_valid;
                if (status.rd_valid && status.data_end && (status.member || status.match))
                begin
                    // rescan the group from its first entry
                    cmd.rd_restart = 1'b1;
                    state_next     = asgl_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.rd_issue = status.more;
                    if (status.rd_valid && status.data_end)
                    begin
                        if (status.data_last)
                        begin
                            state_next = asgl_pkg::ST_FINISH;
                        end
                        else
                        begin
                            cmd.next_group = 1'b1;
                        end
                    end
                    else if (status.rd_valid && status.match)
                    begin
                        cmd.set_member = 1'b1;
                    end
                end
            end
            asgl_pkg::ST_EMIT:
            begin
                if (!block)
                begin
                    cmd.consume   = status.rd_valid;
                    cmd.take_cand = status.rd_valid && !status.match;
                    cmd.rd_issue  = status.more;
                    if (status.rd_valid && status.data_end)
                    begin
                        if (status.data_last)
                        begin
                            state_next = asgl_pkg::ST_FINISH;
                        end
                        else
                        begin
                            cmd.next_group = 1'b1;
                            state_next     = asgl_pkg::ST_MEMBER;
                        end
                    end
                end
            end
            asgl_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_finish = 1'b1;
                    state_next      = asgl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asgl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/asgl_datapath.sv
// ----------------------------------------------------------------------------
// Address substitute group lookup: datapath
// Entry memory, scan pointers, compare, held candidate and output register.
// ----------------------------------------------------------------------------
module asgl_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  asgl_pkg::item_t        item,
    input  asgl_pkg::ctrl_cmd_t    cmd,
    input  logic                   result_stall,
    output asgl_pkg::ctrl_status_t status,
    output asgl_pkg::result_t      result,
    output logic                   result_valid
);

    asgl_pkg::entry_t    entry_mem [asgl_pkg::TABLE_DEPTH];
    asgl_pkg::entry_t    rd_data_reg;
    asgl_pkg::idx_t      rd_idx_reg;
    asgl_pkg::cnt_t      rd_ptr_reg;
    logic                rd_valid_reg;
    asgl_pkg::cnt_t      count_reg;
    asgl_pkg::addr_t     orig_reg;
    logic                full_reg;
    asgl_pkg::idx_t      start_reg;
    asgl_pkg::field_idx_t group_reg;
    logic                member_reg;
    logic                pend_valid_reg;
    asgl_pkg::result_t   pend_reg;
    asgl_pkg::result_t   out_reg;
    logic                out_valid_reg;

    logic                is_full;
    logic                wr_en;
    logic                rd_en;
    asgl_pkg::idx_t      rd_addr;
    logic                out_free;
    logic                out_load;
    asgl_pkg::result_t   out_next;
    asgl_pkg::result_t   cand;

    assign is_full = (count_reg == asgl_pkg::cnt_t'(asgl_pkg::TABLE_DEPTH));
    assign wr_en   = cmd.accept && (item.cmd == asgl_pkg::CMD_APPEND) && !is_full;
    assign rd_en   = cmd.rd_issue || cmd.rd_restart;
    assign rd_addr = cmd.rd_restart ? start_reg : rd_ptr_reg[asgl_pkg::IDX_W-1:0];
    assign out_free = !out_valid_reg || !result_stall;

    assign status.count_zero = (count_reg == '0);
    assign status.more       = (rd_ptr_reg < count_reg);
    assign status.rd_valid   = rd_valid_reg;
    assign status.match      = (rd_data_reg.addr == orig_reg);
    assign status.data_last  = (asgl_pkg::cnt_t'(rd_idx_reg) + asgl_pkg::cnt_t'(1)) == count_reg;
    assign status.data_end   = rd_data_reg.mark || status.data_last;
    assign status.member     = member_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    always_comb
    begin
        cand                = '0;
        cand.result_address = asgl_pkg::field_addr_t'(rd_data_reg.addr);
        cand.group_number   = group_reg;
        cand.entry_in_group = asgl_pkg::field_idx_t'(asgl_pkg::idx_t'(rd_idx_reg - start_reg));
        cand.has_subst      = 1'b1;
    end

    always_comb
    begin
        out_load = 1'b0;
        out_next = '0;
        if (cmd.take_cand && pend_valid_reg)
        begin
            out_load = 1'b1;
            out_next = pend_reg;
        end
        else if (cmd.load_single)
        begin
            out_load        = 1'b1;
            out_next.last   = 1'b1;
            out_next.status = full_reg;
        end
        else if (cmd.load_finish)
        begin
            out_load = 1'b1;
            if (pend_valid_reg)
            begin
                out_next = pend_reg;
            end
            out_next.last = 1'b1;
        end
    end

    // entry memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[count_reg[asgl_pkg::IDX_W-1:0]] <=
                '{mark: item.ends_group, addr: asgl_pkg::addr_t'(item.address)};
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (item.cmd == asgl_pkg::CMD_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + asgl_pkg::cnt_t'(1);
            end

            if (cmd.accept)
            begin
                rd_valid_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (cmd.consume)
            begin
                rd_valid_reg <= 1'b0;
            end

            if (cmd.accept || cmd.load_finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.take_cand)
            begin
                pend_valid_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            orig_reg   <= asgl_pkg::addr_t'(item.address);
            full_reg   <= (item.cmd == asgl_pkg::CMD_APPEND) && is_full;
            rd_ptr_reg <= '0;
            start_reg  <= '0;
            group_reg  <= '0;
            member_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_restart)
            begin
                rd_ptr_reg <= asgl_pkg::cnt_t'(start_reg) + asgl_pkg::cnt_t'(1);
            end
            else if (cmd.rd_issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + asgl_pkg::cnt_t'(1);
            end
            if (cmd.next_group)
            begin
                start_reg  <= rd_idx_reg + asgl_pkg::idx_t'(1);
                group_reg  <= group_reg + asgl_pkg::field_idx_t'(1);
                member_reg <= 1'b0;
            end
            else if (cmd.set_member)
            begin
                member_reg <= 1'b1;
            end
        end
        if (rd_en)
        begin
            rd_idx_reg <= rd_addr;
        end
        if (cmd.take_cand)
        begin
            pend_reg <= cand;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

### rtl/address_substitute_group_lookup.sv
// ----------------------------------------------------------------------------
// Address substitute group lookup: top level
// Ordered groups of addresses; a query returns the other members of every
// group holding the queried address.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item) takes one command word: clear,
//   append or query. item_stall is high from acceptance until the last result
//   word of that command is loaded into the output register.
//   result channel (result_valid/result_stall/result) gives one word for clear,
//   append and unused codes, and one word per substitute for a query, the
//   final word flagged last; a query with no substitute gives one word with
//   has_subst low.
//   Clear and append: the controller passes through ST_SINGLE, which loads the
//   result word once the output register is free, then returns to idle for the
//   next command. Query: the entry memory is read one entry a cycle while the
//   scan is not paused, each entry once for the membership pass and again for
//   groups that hold the address, all through the single read port.
//   Reset empties the table and drops any result word in flight.
//   A stalled result word holds; the scan pauses when a further substitute
//   is found while one waits behind a stalled result word.
// ----------------------------------------------------------------------------
`include "address_substitute_group_lookup_defines.svh"

module address_substitute_group_lookup (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  asgl_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output asgl_pkg::result_t result
);

    asgl_pkg::ctrl_cmd_t    cmd;
    asgl_pkg::ctrl_status_t status;

    asgl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    asgl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    `ASGL_ASSERT(a_idle_no_pending, !item_stall |-> !status.pend_valid, "candidate held while idle")
    `ASGL_ASSERT(a_push_has_room,
        (cmd.take_cand && status.pend_valid) |-> status.out_free, "push into busy output")
    `ASGL_ASSERT(a_restart_at_end,
        cmd.rd_restart |-> (status.rd_valid && status.data_end), "rescan away from group end")
    `ASGL_ASSERT_ALWAYS(a_plain_is_last,
        (result_valid && !result.has_subst) |-> result.last, "plain word not last")

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address substitute group lookup: testbench
// Drives clear, append, query and unused command words through the item
// channel with random gaps. A scoreboard keeps its own copy of the grouped
// address table and predicts every result word. Each received word is
// checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam asgl_pkg::cmd_code_t CMD_UNUSED  = 2'd3;
    localparam int unsigned         CYCLE_LIMIT = 1000000;
    localparam int unsigned         HOLD_CYCLES = 400;
    localparam int unsigned         ITEM_TARGET = 240;

    class lookup_board;
        asgl_pkg::addr_t   stored_addr [asgl_pkg::TABLE_DEPTH];
        logic              stored_mark [asgl_pkg::TABLE_DEPTH];
        int unsigned       fill;
        asgl_pkg::result_t awaited_words [$];
        int unsigned       mismatch_count;

        function new();
            fill           = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned backlog();
            return awaited_words.size();
        endfunction

        function void predict_query(asgl_pkg::addr_t probe);
            asgl_pkg::result_t found [$];
            asgl_pkg::result_t r;
            int unsigned       first;
            int unsigned       grp;
            int unsigned       i;
            int unsigned       j;
            logic              hit;
            first = 0;
            grp   = 0;
            for (i = 0; i < fill; i++)
            begin
                if (stored_mark[i] || i + 1 == fill)
                begin
                    hit = 1'b0;
                    for (j = first; j <= i; j++)
                    begin
                        if (stored_addr[j] == probe)
                            hit = 1'b1;
                    end
                    if (hit)
                    begin
                        for (j = first; j <= i; j++)
                        begin
                            if (stored_addr[j] != probe)
                            begin
                                r                = '0;
                                r.result_address = asgl_pkg::field_addr_t'(stored_addr[j]);
                                r.group_number   = asgl_pkg::field_idx_t'(grp);
                                r.entry_in_group = asgl_pkg::field_idx_t'(j - first);
                                r.has_subst      = 1'b1;
                                found.push_back(r);
                            end
                        end
                    end
                    grp++;
                    first = i + 1;
                end
            end
            if (found.size() == 0)
            begin
                r      = '0;
                r.last = 1'b1;
                found.push_back(r);
            end
            else
                found[found.size() - 1].last = 1'b1;
            foreach (found[k])
                awaited_words.push_back(found[k]);
        endfunction

        function void note_command(asgl_pkg::item_t w);
            asgl_pkg::result_t done_word;
            done_word      = '0;
            done_word.last = 1'b1;
            case (w.cmd)
                asgl_pkg::CMD_CLEAR:
                begin
                    fill = 0;
                    awaited_words.push_back(done_word);
                end
                asgl_pkg::CMD_APPEND:
                begin
                    if (fill >= asgl_pkg::TABLE_DEPTH)
                        done_word.status = 1'b1;
                    else
                    begin
                        stored_addr[fill] = asgl_pkg::addr_t'(w.address);
                        stored_mark[fill] = w.ends_group;
                        fill++;
                    end
                    awaited_words.push_back(done_word);
                end
                asgl_pkg::CMD_QUERY:
                    predict_query(asgl_pkg::addr_t'(w.address));
                default:
                    awaited_words.push_back(done_word);
            endcase
        endfunction

        function void check_word(asgl_pkg::result_t got);
            asgl_pkg::result_t want;
            logic              bad;
            if (awaited_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: addr %h grp %0d ent %0d sub %b last %b st %b",
                             got.result_address, got.group_number, got.entry_in_group,
                             got.has_subst, got.last, got.status);
                return;
            end
            want = awaited_words.pop_front();
            bad  = (got.result_address !== want.result_address)
                || (got.group_number   !== want.group_number)
                || (got.entry_in_group !== want.entry_in_group)
                || (got.has_subst      !== want.has_subst)
                || (got.last           !== want.last)
                || (got.status         !== want.status);
            if (bad)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("wrong word: want addr %h grp %0d ent %0d sub %b last %b st %b",
                             want.result_address, want.group_number, want.entry_in_group,
                             want.has_subst, want.last, want.status,
                             " | got addr %h grp %0d ent %0d sub %b last %b st %b",
                             got.result_address, got.group_number, got.entry_in_group,
                             got.has_subst, got.last, got.status);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    asgl_pkg::item_t   item_word;
    logic              result_valid;
    logic              result_stall;
    asgl_pkg::result_t result_word;

    lookup_board board;
    int unsigned sent;
    int unsigned cycle_count;
    logic        no_idle;
    logic        hold_request;

    address_substitute_group_lookup uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        board       = new();
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("address_substitute_group_lookup: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_word(result_word);
    end

    initial
    begin : receiver
        int unsigned held;
        logic        hold_done;
        result_stall = 1'b0;
        hold_done    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                result_stall = 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            result_stall = !no_idle && ($urandom_range(99) < 8);
        end
    end

    function automatic asgl_pkg::field_addr_t rand_addr();
        return asgl_pkg::field_addr_t'({$urandom(), $urandom()});
    endfunction

    task automatic send_word(asgl_pkg::cmd_code_t c, asgl_pkg::field_addr_t a, logic e);
        asgl_pkg::item_t w;
        int unsigned     gap;
        w.cmd        = c;
        w.address    = a;
        w.ends_group = e;
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 8)
        begin
            item_valid = 1'b0;
            gap        = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
        end
        item_word  = w;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall);
        board.note_command(w);
        if (c != CMD_UNUSED)
            sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (board.backlog() != 0)
            @(negedge clk);
    endtask

    task automatic run_session(logic force_full);
        asgl_pkg::field_addr_t pool [8];
        asgl_pkg::field_addr_t head;
        int unsigned           n;
        int unsigned           q;
        int unsigned           k;
        pool[0] = '0;
        pool[1] = '1;
        for (k = 2; k < 8; k++)
            pool[k] = rand_addr();
        if (force_full)
        begin
            head = rand_addr();
            send_word(asgl_pkg::CMD_CLEAR, rand_addr(), 1'($urandom_range(1)));
            send_word(asgl_pkg::CMD_APPEND, head, 1'b0);
            for (k = 0; k < asgl_pkg::TABLE_DEPTH + 1; k++)
                send_word(asgl_pkg::CMD_APPEND, rand_addr(), 1'b0);
            send_word(asgl_pkg::CMD_QUERY, head, 1'($urandom_range(1)));
            return;
        end
        if ($urandom_range(99) < 75)
            send_word(asgl_pkg::CMD_CLEAR, rand_addr(), 1'($urandom_range(1)));
        n = $urandom_range(1, 14);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 8)
                send_word(CMD_UNUSED, rand_addr(), 1'($urandom_range(1)));
            send_word(asgl_pkg::CMD_APPEND,
                      ($urandom_range(99) < 85) ? pool[3'($urandom_range(7))] : rand_addr(),
                      $urandom_range(99) < 35);
        end
        q = $urandom_range(1, 4);
        for (k = 0; k < q; k++)
            send_word(asgl_pkg::CMD_QUERY,
                      ($urandom_range(99) < 80) ? pool[3'($urandom_range(7))] : rand_addr(),
                      1'($urandom_range(1)));
    endtask

    initial
    begin : stimulus
        asgl_pkg::field_addr_t a_addr;
        asgl_pkg::field_addr_t b_addr;
        asgl_pkg::field_addr_t c_addr;
        asgl_pkg::field_addr_t ones;
        int unsigned           session;
        logic                  hold_issued;
        logic                  pause_done;

        a_addr       = 48'h1234_5678_9abc;
        b_addr       = 48'h8000_0000_0001;
        c_addr       = 48'h5a5a_a5a5_0f0f;
        ones         = '1;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_word    = '0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        sent         = 0;
        hold_issued  = 1'b0;
        pause_done   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(asgl_pkg::CMD_QUERY, a_addr, 1'b0);
        send_word(asgl_pkg::CMD_CLEAR, '0, 1'b0);
        send_word(asgl_pkg::CMD_APPEND, '0, 1'b0);
        send_word(asgl_pkg::CMD_APPEND, ones, 1'b0);
        send_word(asgl_pkg::CMD_APPEND, a_addr, 1'b1);
        send_word(asgl_pkg::CMD_APPEND, a_addr, 1'b0);
        send_word(asgl_pkg::CMD_APPEND, b_addr, 1'b0);
        send_word(asgl_pkg::CMD_APPEND, a_addr, 1'b1);
        send_word(asgl_pkg::CMD_APPEND, '0, 1'b0);
        send_word(asgl_pkg::CMD_APPEND, b_addr, 1'b0);
        send_word(asgl_pkg::CMD_QUERY, a_addr, 1'b1);
        send_word(asgl_pkg::CMD_QUERY, b_addr, 1'b0);
        send_word(asgl_pkg::CMD_QUERY, '0, 1'b1);
        send_word(asgl_pkg::CMD_QUERY, ones, 1'b0);
        send_word(asgl_pkg::CMD_QUERY, c_addr, 1'b1);
        send_word(CMD_UNUSED, ones, 1'b1);
        send_word(asgl_pkg::CMD_CLEAR, ones, 1'b1);
        send_word(asgl_pkg::CMD_QUERY, a_addr, 1'b0);
        send_word(asgl_pkg::CMD_APPEND, a_addr, 1'b1);
        send_word(asgl_pkg::CMD_QUERY, a_addr, 1'b0);

        session = 0;
        while (sent < ITEM_TARGET)
        begin
            if (sent >= 60 && !hold_issued)
            begin
                hold_request = 1'b1;
                hold_issued  = 1'b1;
            end
            if (sent >= 150 && !pause_done)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            no_idle = (sent >= 110 && sent < 170);
            run_session(session == 2);
            session++;
        end

        wait_drained();
        repeat (2 * asgl_pkg::TABLE_DEPTH + 8) @(posedge clk);
        if (board.mismatch_count == 0 && board.backlog() == 0)
            $display("address_substitute_group_lookup: match");
        else
            $display("address_substitute_group_lookup: mismatch");
        $finish;
    end
endmodule
